@@ design/smpq_pkg.sv @@
// Shared types and status codes of the stable minimum priority queue.
package smpq_pkg;

  localparam int unsigned IdentWidth  = 16;
  localparam int unsigned LengthWidth = 16;
  localparam int unsigned OccWidth    = 5;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  typedef struct packed {
    logic                   operation;
    logic [IdentWidth-1:0]  job_ident;
    logic [LengthWidth-1:0] job_length;
  } smpq_req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [IdentWidth-1:0]  out_ident;
    logic [LengthWidth-1:0] out_length;
    logic [OccWidth-1:0]    occupancy;
  } smpq_rsp_t;

  typedef struct packed {
    logic [IdentWidth-1:0]  ident;
    logic [LengthWidth-1:0] length;
  } smpq_entry_t;

  localparam int unsigned EntryWidth = IdentWidth + LengthWidth;

endpackage

@@ design/stable_min_priority_queue_top.sv @@
// Stable shortest-job-first queue: one item at a time.
// An empty dequeue, a full enqueue and an enqueue into an empty queue are
// answered from the idle state; a dequeue first reads the head; an enqueue
// walks over the stored jobs it passes one at a time, through the
// single read port of the job memory. busy is high until the result strobe.
// Reset clears the state, count, head pointer, walk position and strobe; memory contents are not cleared.
module stable_min_priority_queue_top
  import smpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  smpq_req_t req_i,
  output logic      done_o,
  output smpq_rsp_t rsp_o
);

  // Address width of the job memory and width of the occupancy counter.
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned SW = AW + 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // The stored jobs form a sorted ring: logical slot k lives at physical address
  // head + k, taken modulo the depth. A dequeue therefore only advances the head,
  // and an enqueue walks from the tail towards the head, moving each longer job
  // up by one slot until it meets a job whose length is less than or equal to the
  // new one. Stopping at equal lengths keeps jobs of equal length in arrival order.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DEQ   = 4'b0010,
    S_SHIFT = 4'b0100,
    S_PLACE = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  smpq_entry_t job_q, job_d;
  smpq_rsp_t   rsp_q, rsp_d;
  logic        done_q, done_d;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  smpq_entry_t   wr_data;
  logic [EntryWidth-1:0] rd_raw;
  smpq_entry_t   rd_data;

  // Map a logical slot to its physical address; the sum stays below twice the
  // depth, so one compare and subtract folds it back into range.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(k);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // The reported occupancy is the count folded into the low five bits.
  function automatic logic [OccWidth-1:0] occ(input logic [CW-1:0] c);
    logic [31:0] t;
    t = 32'(c);
    return t[OccWidth-1:0];
  endfunction

  smpq_ram #(
    .WIDTH (EntryWidth),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_raw)
  );

  assign rd_data = smpq_entry_t'(rd_raw);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    job_d   = job_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = job_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          job_d = '{ident: req_i.job_ident, length: req_i.job_length};
          if (req_i.operation == OP_DEQUEUE) begin
            if (count_q == '0) begin
              rsp_d  = '{status: ST_EMPTY, out_ident: '0, out_length: '0,
                         occupancy: occ(count_q)};
              done_d = 1'b1;
            end else begin
              // Fetch the head; the shortest job is always in logical slot zero.
              rd_en   = 1'b1;
              rd_addr = head_q;
              state_d = S_DEQ;
            end
          end else if (count_q == CW'(QUEUE_DEPTH)) begin
            rsp_d  = '{status: ST_FULL, out_ident: '0, out_length: '0,
                       occupancy: occ(count_q)};
            done_d = 1'b1;
          end else if (count_q == '0) begin
            wr_en   = 1'b1;
            wr_addr = head_q;
            wr_data = '{ident: req_i.job_ident, length: req_i.job_length};
            count_d = CW'(1);
            rsp_d   = '{status: ST_ENQUEUED, out_ident: '0, out_length: '0,
                        occupancy: occ(CW'(1))};
            done_d  = 1'b1;
          end else begin
            // Start the walk at the tail: read the last job, target the free slot.
            rd_en   = 1'b1;
            rd_addr = phys(head_q, count_q - CW'(1));
            pos_d   = count_q;
            state_d = S_SHIFT;
          end
        end
      end

      S_DEQ: begin
        rsp_d   = '{status: ST_DEQUEUED, out_ident: rd_data.ident,
                    out_length: rd_data.length, occupancy: occ(count_q - CW'(1))};
        done_d  = 1'b1;
        head_d  = phys(head_q, CW'(1));
        count_d = count_q - CW'(1);
        state_d = S_IDLE;
      end

      S_SHIFT: begin
        // The read data holds the job in logical slot pos - 1. The next read,
        // issued in the same cycle, targets pos - 2, which this walk never writes
        // before reading, so no forwarding is needed.
        wr_en   = 1'b1;
        wr_addr = phys(head_q, pos_q);
        if (rd_data.length > job_q.length) begin
          wr_data = rd_data;
          pos_d   = pos_q - CW'(1);
          if (pos_q == CW'(1)) begin
            state_d = S_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = phys(head_q, pos_q - CW'(2));
          end
        end else begin
          wr_data = job_q;
          count_d = count_q + CW'(1);
          rsp_d   = '{status: ST_ENQUEUED, out_ident: '0, out_length: '0,
                      occupancy: occ(count_q + CW'(1))};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_PLACE: begin
        // Every stored job was longer: the new job becomes the head.
        wr_en   = 1'b1;
        wr_addr = head_q;
        wr_data = job_q;
        count_d = count_q + CW'(1);
        rsp_d   = '{status: ST_ENQUEUED, out_ident: '0, out_length: '0,
                    occupancy: occ(count_q + CW'(1))};
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    rsp_q <= rsp_d;
  end

  // A new transfer is taken only in the idle state; the result register is
  // refilled at most once per item, so the strobe lasts a single cycle.
  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ design/smpq_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module smpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
